[src/serq_pkg.sv]
// Shared types and constants for the sorted event range query core.
`timescale 1ns / 1ps

package serq_pkg;

    localparam int DATE_W       = 48;
    localparam int ID_W         = 32;
    localparam int USER_W       = 32;
    localparam int NUM_TAG_REGS = 4;
    localparam int MAX_TAGS     = 4;
    localparam int ACTIVE_MAX   = (MAX_TAGS < NUM_TAG_REGS) ? MAX_TAGS : NUM_TAG_REGS;
    localparam int TAG_CNT_W    = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int ACTION_W     = 2;
    localparam int STATUS_W     = 2;

    localparam logic [ACTION_W-1:0] ACT_LOAD  = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_QUERY = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_RECORD = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_EMPTY  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_NO_TAG = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_TAG_COUNT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TAG_ZERO  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TAG_ONE   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TAG_TWO   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_TAG_THREE = 3'd4;

    // date sits in the low bits so the record maps straight onto tdata
    typedef struct packed {
        logic [USER_W-1:0] user;
        logic [ID_W-1:0]   id;
        logic [DATE_W-1:0] date;
    } rec_t;

    localparam int REC_W = $bits(rec_t);

    typedef struct packed {
        logic we;
        logic re;
    } ram_ctl_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PROBE,
        ST_CMP,
        ST_EMPTY,
        ST_SCAN_RD,
        ST_SCAN_CHK,
        ST_FLUSH
    } state_t;

endpackage

[src/serq_ram.sv]
// Generic single-port-write, registered-read RAM.
`timescale 1ns / 1ps

module serq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[src/serq_ctrl.sv]
// Sequencer: table loads, two bound searches, range scan and output register.
`timescale 1ns / 1ps

module serq_ctrl #(
    parameter int DEPTH = 64
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [serq_pkg::ACTION_W-1:0] in_action,
    input  serq_pkg::rec_t              in_rec,
    input  logic [serq_pkg::DATE_W-1:0] in_end_date,
    output logic                        out_valid,
    input  logic                        out_ready,
    output serq_pkg::rec_t              out_rec,
    output logic [serq_pkg::STATUS_W-1:0] out_status,
    output logic                        out_last,
    output serq_pkg::ram_ctl_t          ram_ctl,
    output logic [$clog2(DEPTH)-1:0]    ram_addr,
    input  serq_pkg::rec_t              ram_rdata,
    input  logic                        rd_match
);

    import serq_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    state_t                state_reg, state_next;
    logic [CNT_W-1:0]      cnt_reg, cnt_next;
    logic [CNT_W-1:0]      lo_reg, lo_next;
    logic [CNT_W-1:0]      hi_reg, hi_next;
    logic [CNT_W-1:0]      first_reg, first_next;
    logic [DATE_W-1:0]     key_lo_reg, key_lo_next;
    logic [DATE_W-1:0]     key_hi_reg, key_hi_next;
    logic                  upper_reg, upper_next;
    rec_t                  pend_reg, pend_next;
    logic                  pend_valid_reg, pend_valid_next;
    rec_t                  out_rec_reg, out_rec_next;
    logic [STATUS_W-1:0]   out_status_reg, out_status_next;
    logic                  out_last_reg, out_last_next;
    logic                  out_valid_reg, out_valid_next;

    logic [CNT_W:0]        mid_sum;
    logic [CNT_W-1:0]      mid;
    logic                  out_free;
    logic                  below;
    logic [DATE_W-1:0]     key;

    assign mid_sum  = {1'b0, lo_reg} + {1'b0, hi_reg};
    assign mid      = mid_sum[CNT_W:1];
    assign out_free = !out_valid_reg || out_ready;
    assign key      = upper_reg ? key_hi_reg : key_lo_reg;
    assign below    = upper_reg ? (ram_rdata.date <= key) : (ram_rdata.date < key);

    assign in_ready   = (state_reg == ST_IDLE);
    assign out_valid  = out_valid_reg;
    assign out_rec    = out_rec_reg;
    assign out_status = out_status_reg;
    assign out_last   = out_last_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid && in_action == ACT_QUERY)
                begin
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                if (lo_reg < hi_reg)
                begin
                    state_next = ST_CMP;
                end
                else if (upper_reg)
                begin
                    state_next = (first_reg >= lo_reg) ? ST_EMPTY : ST_SCAN_RD;
                end
            end
            ST_CMP:
            begin
                state_next = ST_PROBE;
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_SCAN_RD:
            begin
                state_next = (lo_reg < hi_reg) ? ST_SCAN_CHK : ST_FLUSH;
            end
            ST_SCAN_CHK:
            begin
                if (!rd_match || !pend_valid_reg || out_free)
                begin
                    state_next = ST_SCAN_RD;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        cnt_next        = cnt_reg;
        lo_next         = lo_reg;
        hi_next         = hi_reg;
        first_next      = first_reg;
        key_lo_next     = key_lo_reg;
        key_hi_next     = key_hi_reg;
        upper_next      = upper_reg;
        pend_next       = pend_reg;
        pend_valid_next = pend_valid_reg;
        out_rec_next    = out_rec_reg;
        out_status_next = out_status_reg;
        out_last_next   = out_last_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        ram_ctl         = '0;
        ram_addr        = lo_reg[ADDR_W-1:0];
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    unique case (in_action)
                        ACT_LOAD:
                        begin
                            ram_addr = cnt_reg[ADDR_W-1:0];
                            if (cnt_reg < CNT_W'(DEPTH))
                            begin
                                ram_ctl.we = 1'b1;
                                cnt_next   = cnt_reg + 1'b1;
                            end
                        end
                        ACT_QUERY:
                        begin
                            if (in_rec.date > in_end_date)
                            begin
                                key_lo_next = in_end_date;
                                key_hi_next = in_rec.date;
                            end
                            else
                            begin
                                key_lo_next = in_rec.date;
                                key_hi_next = in_end_date;
                            end
                            upper_next      = 1'b0;
                            lo_next         = '0;
                            hi_next         = cnt_reg;
                            pend_valid_next = 1'b0;
                        end
                        ACT_CLEAR:
                        begin
                            cnt_next = '0;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            ST_PROBE:
            begin
                ram_addr = mid[ADDR_W-1:0];
                if (lo_reg < hi_reg)
                begin
                    ram_ctl.re = 1'b1;
                end
                else if (!upper_reg)
                begin
                    first_next = lo_reg;
                    upper_next = 1'b1;
                    lo_next    = '0;
                    hi_next    = cnt_reg;
                end
                else
                begin
                    // scan runs from the lower bound up to the upper one
                    lo_next = first_reg;
                end
            end
            ST_CMP:
            begin
                if (below)
                begin
                    lo_next = mid + 1'b1;
                end
                else
                begin
                    hi_next = mid;
                end
            end
            ST_EMPTY:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_rec_next    = '0;
                    out_status_next = STAT_EMPTY;
                    out_last_next   = 1'b1;
                end
            end
            ST_SCAN_RD:
            begin
                if (lo_reg < hi_reg)
                begin
                    ram_ctl.re = 1'b1;
                end
            end
            ST_SCAN_CHK:
            begin
                // one record is held back so the final one can carry last
                if (!rd_match)
                begin
                    lo_next = lo_reg + 1'b1;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        out_valid_next  = 1'b1;
                        out_rec_next    = pend_reg;
                        out_status_next = STAT_RECORD;
                        out_last_next   = 1'b0;
                    end
                    pend_next       = ram_rdata;
                    pend_valid_next = 1'b1;
                    lo_next         = lo_reg + 1'b1;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_last_next   = 1'b1;
                    pend_valid_next = 1'b0;
                    if (pend_valid_reg)
                    begin
                        out_rec_next    = pend_reg;
                        out_status_next = STAT_RECORD;
                    end
                    else
                    begin
                        out_rec_next    = '0;
                        out_status_next = STAT_NO_TAG;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            cnt_reg        <= '0;
            lo_reg         <= '0;
            hi_reg         <= '0;
            first_reg      <= '0;
            upper_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            lo_reg         <= lo_next;
            hi_reg         <= hi_next;
            first_reg      <= first_next;
            upper_reg      <= upper_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_lo_reg     <= key_lo_next;
        key_hi_reg     <= key_hi_next;
        pend_reg       <= pend_next;
        out_rec_reg    <= out_rec_next;
        out_status_reg <= out_status_next;
        out_last_reg   <= out_last_next;
    end

endmodule

[src/sorted_event_range_query_core.sv]
// Top level: config registers, tag filter, record RAM and sequencer.
//
// Date-ordered event table with range query.
// s_axis carries one transaction per action (tuser): load a record, run a
// range query or clear the table. Loads and clears give no result; loads
// past DEPTH records are dropped.
// A query runs two binary searches over the stored records (lower and upper
// date bound), then scans the range. Every probe and every scanned record
// goes through the one registered RAM read. The input side takes nothing
// else until the query's last result sits in the output register.
// m_axis gives one transaction per matching record, tlast on the final one;
// an empty range or a fully filtered range gives one status transaction.
// A stalled receiver holds the output register and the scan waits on it.
// The cfg channel is always ready and writes tag_count and the four tags;
// it is meant to be used only while the block is idle.
// Reset (rst_n, asynchronous) empties the table and zeroes the control and tag registers.
`timescale 1ns / 1ps

module sorted_event_range_query_core #(
    parameter int DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // date_value[47:0], range_end_date[95:48], event_id[127:96], user_value[159:128]
    input  logic [159:0] s_axis_tdata,
    // action[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // out_date[47:0], out_id[79:48], out_user[111:80]
    output logic [111:0] m_axis_tdata,
    // status[1:0]
    output logic [1:0]   m_axis_tuser,
    output logic         m_axis_tlast,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [2:0]   cfg_index,
    input  logic [31:0]  cfg_data
);

    import serq_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    logic [TAG_CNT_W-1:0] tag_count_reg;
    logic [ID_W-1:0]      tag_reg [NUM_TAG_REGS];
    logic [TAG_CNT_W-1:0] active_tags;
    logic                 rd_match;
    rec_t                 in_rec;
    rec_t                 ram_rdata;
    rec_t                 out_rec;
    ram_ctl_t             ram_ctl;
    logic [ADDR_W-1:0]    ram_addr;
    logic [REC_W-1:0]     ram_rdata_raw;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tag_count_reg <= '0;
            for (int i = 0; i < NUM_TAG_REGS; i++)
            begin
                tag_reg[i] <= '0;
            end
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_TAG_COUNT: tag_count_reg <= cfg_data[TAG_CNT_W-1:0];
                REG_TAG_ZERO:  tag_reg[0]    <= cfg_data;
                REG_TAG_ONE:   tag_reg[1]    <= cfg_data;
                REG_TAG_TWO:   tag_reg[2]    <= cfg_data;
                REG_TAG_THREE: tag_reg[3]    <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign active_tags = (tag_count_reg > TAG_CNT_W'(ACTIVE_MAX)) ?
                         TAG_CNT_W'(ACTIVE_MAX) : tag_count_reg;

    // no active tags lets every record through
    always_comb
    begin
        rd_match = (active_tags == '0);
        for (int t = 0; t < NUM_TAG_REGS; t++)
        begin
            if ((TAG_CNT_W'(t) < active_tags) && (tag_reg[t] == ram_rdata.id))
            begin
                rd_match = 1'b1;
            end
        end
    end

    assign in_rec.date = s_axis_tdata[47:0];
    assign in_rec.id   = s_axis_tdata[127:96];
    assign in_rec.user = s_axis_tdata[159:128];
    assign ram_rdata   = rec_t'(ram_rdata_raw);

    serq_ram #(
        .WIDTH (REC_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (ram_ctl.we),
        .waddr (ram_addr),
        .wdata (in_rec),
        .re    (ram_ctl.re),
        .raddr (ram_addr),
        .rdata (ram_rdata_raw)
    );

    serq_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .in_action   (s_axis_tuser),
        .in_rec      (in_rec),
        .in_end_date (s_axis_tdata[95:48]),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .out_rec     (out_rec),
        .out_status  (m_axis_tuser),
        .out_last    (m_axis_tlast),
        .ram_ctl     (ram_ctl),
        .ram_addr    (ram_addr),
        .ram_rdata   (ram_rdata),
        .rd_match    (rd_match)
    );

    assign m_axis_tdata = out_rec;

endmodule

[src/serq_checker.sv]
// Port-level assertions for the sorted event range query core, with bind.
`timescale 1ns / 1ps

module serq_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [111:0] m_axis_tdata,
    input logic [1:0]   m_axis_tuser,
    input logic         m_axis_tlast
);

    import serq_pkg::*;

    // a status result always closes its query
    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != STAT_RECORD) |-> m_axis_tlast)
        else $error("status result without tlast");

    a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != STAT_RECORD) |-> (m_axis_tdata == '0))
        else $error("status result with nonzero record fields");

    // while a query is still scanning, no new input is taken
    a_busy_scan: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
        else $error("input ready while query results are pending");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled output transaction changed");

endmodule

bind sorted_event_range_query_core serq_checker u_serq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

[tb/tb_sorted_event_range_query_core.sv]
// Self-checking testbench for the sorted event range query core.
`timescale 1ns / 1ps

module tb_sorted_event_range_query_core;
    import serq_pkg::*;

    localparam int TBL_DEPTH   = 64;
    localparam int HOLD_CYCLES = 400;
    localparam int SEGMENTS    = 9;
    localparam int SEG_ITEMS   = 32;
    localparam int SETTLE      = 8;
    localparam int LIMIT_NS    = 30000000;

    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam logic [DATE_W-1:0]   DATE_MAX   = {DATE_W{1'b1}};
    localparam logic [ID_W-1:0]     ID_MAX     = {ID_W{1'b1}};

    typedef struct packed {
        logic [ACTION_W-1:0] action;
        logic [DATE_W-1:0]   lo_date;
        logic [DATE_W-1:0]   hi_date;
        logic [ID_W-1:0]     id;
        logic [USER_W-1:0]   user;
    } event_item_t;

    typedef struct packed {
        logic [DATE_W-1:0]   date;
        logic [ID_W-1:0]     id;
        logic [USER_W-1:0]   user;
        logic [STATUS_W-1:0] status;
        logic                last;
    } query_result_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                s_axis_tvalid = 1'b0;
    logic                s_axis_tready;
    logic [159:0]        s_axis_tdata = '0;
    logic [1:0]          s_axis_tuser = '0;
    logic                m_axis_tvalid;
    logic                m_axis_tready = 1'b0;
    logic [111:0]        m_axis_tdata;
    logic [1:0]          m_axis_tuser;
    logic                m_axis_tlast;
    logic                cfg_valid = 1'b0;
    logic                cfg_ready;
    logic [2:0]          cfg_index = '0;
    logic [31:0]         cfg_data = '0;

    sorted_event_range_query_core #(
        .DEPTH(TBL_DEPTH)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // shadow of the event table and filter registers
    logic [DATE_W-1:0]    tbl_date [TBL_DEPTH];
    logic [ID_W-1:0]      tbl_id   [TBL_DEPTH];
    logic [USER_W-1:0]    tbl_user [TBL_DEPTH];
    int                   tbl_count = 0;
    logic [TAG_CNT_W-1:0] tag_count_q = '0;
    logic [ID_W-1:0]      tag_q [NUM_TAG_REGS] = '{default: '0};

    query_result_t pending_results[$];
    event_item_t   queued_events[$];
    event_item_t   cur_item;

    // stimulus-side view of the table, used to aim query bounds
    logic [DATE_W-1:0] gen_dates [TBL_DEPTH];
    int                gen_count = 0;
    int                gen_added = 0;

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_req = 0;
    int hold_seen = 0;
    int hold_left = 0;

    int errors = 0;
    int items_accepted = 0;
    int query_count = 0;
    int drop_count = 0;
    int status_count = 0;
    int results_seen = 0;
    int filter_settings = 0;

    function automatic int count_dates_below(logic [DATE_W-1:0] key, bit inclusive);
        int lo_i;
        int hi_i;
        int mid;
        lo_i = 0;
        hi_i = tbl_count;
        while (lo_i < hi_i)
        begin
            mid = (lo_i + hi_i) / 2;
            if (inclusive ? (tbl_date[mid] <= key) : (tbl_date[mid] < key))
                lo_i = mid + 1;
            else
                hi_i = mid;
        end
        return lo_i;
    endfunction

    function automatic bit id_accepted(logic [ID_W-1:0] id_v);
        int n;
        n = (tag_count_q > ACTIVE_MAX) ? ACTIVE_MAX : tag_count_q;
        if (n == 0)
            return 1'b1;
        for (int t = 0; t < n; t++)
            if (tag_q[t] == id_v)
                return 1'b1;
        return 1'b0;
    endfunction

    task automatic apply_event(event_item_t it);
        logic [DATE_W-1:0]   lo_d;
        logic [DATE_W-1:0]   hi_d;
        logic [STATUS_W-1:0] stat;
        int                  lo_idx;
        int                  hi_idx;
        bit                  have_prev;
        query_result_t       prev;
        case (it.action)
            ACT_LOAD:
            begin
                if (tbl_count < TBL_DEPTH)
                begin
                    tbl_date[tbl_count] = it.lo_date;
                    tbl_id[tbl_count]   = it.id;
                    tbl_user[tbl_count] = it.user;
                    tbl_count++;
                end
                else
                    drop_count++;
            end
            ACT_CLEAR: tbl_count = 0;
            ACT_QUERY:
            begin
                query_count++;
                lo_d = it.lo_date;
                hi_d = it.hi_date;
                if (lo_d > hi_d)
                begin
                    lo_d = it.hi_date;
                    hi_d = it.lo_date;
                end
                lo_idx = count_dates_below(lo_d, 1'b0);
                hi_idx = count_dates_below(hi_d, 1'b1);
                stat = STAT_RECORD;
                have_prev = 1'b0;
                prev = '0;
                if (lo_idx >= hi_idx)
                    stat = STAT_EMPTY;
                else
                begin
                    // hold back each record one step so the final one gets last
                    for (int i = lo_idx; i < hi_idx; i++)
                    begin
                        if (id_accepted(tbl_id[i]))
                        begin
                            if (have_prev)
                                pending_results.push_back(prev);
                            prev.date   = tbl_date[i];
                            prev.id     = tbl_id[i];
                            prev.user   = tbl_user[i];
                            prev.status = STAT_RECORD;
                            prev.last   = 1'b0;
                            have_prev   = 1'b1;
                        end
                    end
                    if (have_prev)
                    begin
                        prev.last = 1'b1;
                        pending_results.push_back(prev);
                    end
                    else
                        stat = STAT_NO_TAG;
                end
                if (stat != STAT_RECORD)
                begin
                    prev = '0;
                    prev.status = stat;
                    prev.last = 1'b1;
                    pending_results.push_back(prev);
                    status_count++;
                end
            end
            default: ;
        endcase
    endtask

    // sender: one item held on the bus until its transaction completes
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_event(cur_item);
                items_accepted++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (queued_events.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    cur_item = queued_events.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= {cur_item.user, cur_item.id,
                                      cur_item.hi_date, cur_item.lo_date};
                    s_axis_tuser  <= cur_item.action;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // receiver ready, with a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = HOLD_CYCLES;
        end
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else if (hold_left > 0)
        begin
            hold_left--;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // result checker
    always @(posedge clk)
    begin
        query_result_t got;
        query_result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.date   = m_axis_tdata[DATE_W-1:0];
            got.id     = m_axis_tdata[DATE_W+ID_W-1:DATE_W];
            got.user   = m_axis_tdata[DATE_W+ID_W+USER_W-1:DATE_W+ID_W];
            got.status = m_axis_tuser;
            got.last   = m_axis_tlast;
            results_seen++;
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result, expected none,", $time,
                         " actual date=%h id=%h user=%h status=%0d last=%0d",
                         got.date, got.id, got.user, got.status, got.last);
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.date !== want.date || got.id !== want.id || got.user !== want.user ||
                    got.status !== want.status || got.last !== want.last)
                begin
                    errors++;
                    $display("%0t: mismatch, expected date=%h id=%h user=%h", $time,
                             want.date, want.id, want.user,
                             " status=%0d last=%0d,", want.status, want.last,
                             " actual date=%h id=%h user=%h", got.date, got.id, got.user,
                             " status=%0d last=%0d", got.status, got.last);
                end
            end
        end
    end

    function automatic logic [DATE_W-1:0] rand48();
        logic [63:0] w;
        w = {$urandom, $urandom};
        return w[DATE_W-1:0];
    endfunction

    function automatic logic [DATE_W-1:0] pick_date();
        logic [DATE_W-1:0] d;
        if (gen_count == 0 || $urandom_range(3) == 0)
            return rand48();
        d = gen_dates[$urandom_range(gen_count - 1)];
        case ($urandom_range(2))
            0:       return d - 1'b1;
            1:       return d;
            default: return d + 1'b1;
        endcase
    endfunction

    function automatic logic [ID_W-1:0] pick_id();
        if ($urandom_range(99) < 60)
            return tag_q[$urandom_range(NUM_TAG_REGS - 1)];
        return $urandom;
    endfunction

    task automatic push_event(logic [ACTION_W-1:0] action, logic [DATE_W-1:0] lo,
                              logic [DATE_W-1:0] hi, logic [ID_W-1:0] id,
                              logic [USER_W-1:0] user);
        event_item_t it;
        it.action  = action;
        it.lo_date = lo;
        it.hi_date = hi;
        it.id      = id;
        it.user    = user;
        queued_events.push_back(it);
        if (action != ACT_UNUSED)
            gen_added++;
        if (action == ACT_LOAD && gen_count < TBL_DEPTH)
        begin
            gen_dates[gen_count] = lo;
            gen_count++;
        end
        else if (action == ACT_CLEAR)
            gen_count = 0;
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_TAG_COUNT)
            tag_count_q = val[TAG_CNT_W-1:0];
        else
            tag_q[idx - REG_TAG_ZERO] = val;
    endtask

    task automatic set_filter(int cnt, logic [ID_W-1:0] t0, logic [ID_W-1:0] t1,
                              logic [ID_W-1:0] t2, logic [ID_W-1:0] t3);
        write_reg(REG_TAG_COUNT, cnt);
        write_reg(REG_TAG_ZERO, t0);
        write_reg(REG_TAG_ONE, t1);
        write_reg(REG_TAG_TWO, t2);
        write_reg(REG_TAG_THREE, t3);
        filter_settings++;
    endtask

    // everything sent and answered, then a SETTLE wait for trailing loads
    task automatic wait_idle();
        while (queued_events.size() != 0 || s_axis_tvalid || pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // clear, mostly ascending loads (mostly short, now and then past capacity), then queries
    task automatic well_formed_run();
        int                k;
        int                q;
        logic [DATE_W-1:0] d;
        k = ($urandom_range(9) == 0) ? $urandom_range(70, 60) : $urandom_range(16, 1);
        d = $urandom_range(1) ? rand48() : (rand48() >> 28);
        push_event(ACT_CLEAR, rand48(), rand48(), $urandom, $urandom);
        for (int i = 0; i < k; i++)
        begin
            if ($urandom_range(19) == 0)
                push_event(ACT_LOAD, rand48(), rand48(), pick_id(), $urandom);
            else
            begin
                d = d + $urandom_range(3);
                push_event(ACT_LOAD, d, rand48(), pick_id(), $urandom);
            end
        end
        q = $urandom_range(6, 2);
        for (int i = 0; i < q; i++)
            push_event(ACT_QUERY, pick_date(), pick_date(), $urandom, $urandom);
    endtask

    task automatic fill_segment(int n_items);
        int start;
        start = gen_added;
        while (gen_added - start < n_items)
        begin
            if ($urandom_range(99) < 85)
                well_formed_run();
            else
                push_event(ACTION_W'($urandom_range(3)), rand48(), rand48(),
                           $urandom, $urandom);
        end
    endtask

    initial
    begin
        logic [ID_W-1:0] dup;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_idle_pct = 20;
        recv_idle_pct = 49;
        set_filter(0, 0, 0, 0, 0);
        push_event(ACT_QUERY, 48'd5, 48'd10, 0, 0);          // empty table
        push_event(ACT_LOAD, 48'd0, 48'd0, 0, 0);
        push_event(ACT_LOAD, 48'd0, DATE_MAX, ID_MAX, ID_MAX);
        push_event(ACT_LOAD, 48'd100, 48'd0, 7, 1);
        push_event(ACT_LOAD, 48'd100, 48'd0, 8, 2);
        push_event(ACT_LOAD, 48'd200, 48'd0, 7, 3);
        push_event(ACT_LOAD, DATE_MAX, 48'd0, 9, 4);
        push_event(ACT_QUERY, 48'd0, DATE_MAX, 0, 0);
        push_event(ACT_QUERY, DATE_MAX, 48'd0, 0, 0);       // reversed bounds
        push_event(ACT_QUERY, 48'd101, 48'd199, 0, 0);      // gap between dates
        push_event(ACT_QUERY, 48'd100, 48'd100, 0, 0);
        push_event(ACT_QUERY, DATE_MAX, DATE_MAX, 0, 0);
        push_event(ACT_UNUSED, DATE_MAX, DATE_MAX, ID_MAX, ID_MAX);
        push_event(ACT_QUERY, 48'd0, 48'd0, 0, 0);
        push_event(ACT_QUERY, 48'd201, DATE_MAX - 1'b1, 0, 0);
        wait_idle();

        // saturating count and duplicate tags
        set_filter(7, 7, 7, 9, 0);
        push_event(ACT_QUERY, 48'd0, DATE_MAX, 0, 0);
        push_event(ACT_QUERY, 48'd100, 48'd100, 0, 0);
        wait_idle();

        set_filter(1, 12345, 0, 0, 0);
        push_event(ACT_QUERY, 48'd0, DATE_MAX, 0, 0);       // nothing passes
        push_event(ACT_CLEAR, 0, 0, 0, 0);
        push_event(ACT_QUERY, 48'd0, DATE_MAX, 0, 0);
        push_event(ACT_LOAD, 48'd5, 0, 1, 1);
        push_event(ACT_LOAD, 48'd6, 0, 2, 2);
        push_event(ACT_QUERY, 48'd7, 48'd100, 0, 0);        // every date below range
        push_event(ACT_QUERY, 48'd0, 48'd4, 0, 0);          // every date above range
        wait_idle();

        for (int s = 0; s < SEGMENTS; s++)
        begin
            if (s < 3)
            begin
                send_idle_pct = 20;
                recv_idle_pct = 49;
            end
            else if (s < 6)
            begin
                send_idle_pct = 49;
                recv_idle_pct = 20;
            end
            else
            begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
            end
            dup = $urandom;
            case (s)
                0: set_filter(0, $urandom, $urandom, $urandom, $urandom);
                1: set_filter(1, $urandom, $urandom, $urandom, $urandom);
                2: set_filter(4, $urandom, $urandom, $urandom, $urandom);
                3: set_filter(7, dup, dup, $urandom, $urandom);
                4: set_filter(2, 0, ID_MAX, $urandom, $urandom);
                5: set_filter(3, dup, dup, dup, $urandom);
                6: set_filter(0, $urandom, $urandom, $urandom, $urandom);
                7: set_filter(5, $urandom, $urandom, $urandom, $urandom);
                default: set_filter(4, 0, ID_MAX, $urandom, $urandom);
            endcase
            if (s == 6)
            begin
                // stall the output long enough to back up the input side
                @(negedge clk);
                hold_req++;
            end
            fill_segment(SEG_ITEMS);
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (pending_results.size() != 0)
        begin
            errors++;
            $display("%0t: %0d expected results never arrived", $time, pending_results.size());
        end
        $display("Sent %0d input transactions: %0d queries, %0d loads dropped on a full table",
                 items_accepted, query_count, drop_count);
        $display("Checked %0d result transactions (%0d status) across %0d filter settings",
                 results_seen, status_count, filter_settings);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        #(LIMIT_NS);
        $display("%0t: timeout", $time);
        $display("== FAIL ==");
        $finish;
    end

endmodule
